/* design/bpc_pkg.sv */
// Package for the button press classifier: widths, register indexes, shared types.
package bpc_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] HeldMax = {TickW{1'b1}};

  // Register reset values
  localparam logic [TickW-1:0] DebounceReset = 16'd10;
  localparam logic [TickW-1:0] ShortMaxReset = 16'd1000;
  localparam logic [TickW-1:0] LongReset     = 16'd3000;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_MAX_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_TICKS      = 2'd2;

  typedef struct packed {
    logic [TickW-1:0] debounce_ticks;
    logic [TickW-1:0] short_max_ticks;
    logic [TickW-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
  } result_t;

  typedef struct packed {
    logic pin_edge;
    logic pressed;
    logic debounce_armed;
    logic long_armed;
  } status_t;

endpackage

/* design/bpc_cfg_regs.sv */
// Configuration register file for the button press classifier.
module bpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [bpc_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [bpc_pkg::TickW-1:0]     wr_data,
  output bpc_pkg::cfg_t                 cfg
);
  import bpc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= DebounceReset;
      cfg_r.short_max_ticks <= ShortMaxReset;
      cfg_r.long_ticks      <= LongReset;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEBOUNCE_TICKS:  cfg_r.debounce_ticks  <= wr_data;
        CFG_SHORT_MAX_TICKS: cfg_r.short_max_ticks <= wr_data;
        CFG_LONG_TICKS:      cfg_r.long_ticks      <= wr_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/bpc_step.sv */
// Per-tick classifier state and next-state logic: countdowns, debounced state, held time.
module bpc_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              level,
  input  bpc_pkg::cfg_t     cfg,
  output bpc_pkg::result_t  result,
  output bpc_pkg::status_t  status
);
  import bpc_pkg::*;

  logic             prev_level_r, prev_level_nxt;
  logic [TickW-1:0] db_left_r, db_left_nxt;
  logic             db_armed_r, db_armed_nxt;
  logic [TickW-1:0] lg_left_r, lg_left_nxt;
  logic             lg_armed_r, lg_armed_nxt;
  logic             pressed_r, pressed_nxt;
  logic [TickW-1:0] held_r, held_nxt;

  logic             pin_edge;
  logic             pressed_now;
  logic [TickW-1:0] held_inc;
  logic [TickW-1:0] db_dec, lg_dec;
  logic             db_fire, lg_fire;

  always_comb begin
    pressed_now = ~level;
    pin_edge    = (level != prev_level_r);
    held_inc    = (held_r == HeldMax) ? held_r : held_r + 1'b1;

    // a zero count fires on the next tick just like one
    db_dec  = (db_left_r != '0) ? db_left_r - 1'b1 : db_left_r;
    lg_dec  = (lg_left_r != '0) ? lg_left_r - 1'b1 : lg_left_r;
    db_fire = !pin_edge && db_armed_r && (db_dec == '0);
    lg_fire = !pin_edge && lg_armed_r && (lg_dec == '0);

    prev_level_nxt = level;
    pressed_nxt    = pressed_r;
    held_nxt       = held_inc;
    result         = '0;

    if (pin_edge) begin
      db_left_nxt  = cfg.debounce_ticks;
      db_armed_nxt = 1'b1;
      lg_left_nxt  = cfg.long_ticks;
      lg_armed_nxt = 1'b1;
    end else begin
      db_left_nxt  = db_armed_r ? db_dec : db_left_r;
      db_armed_nxt = db_armed_r && !db_fire;
      lg_left_nxt  = lg_armed_r ? lg_dec : lg_left_r;
      lg_armed_nxt = lg_armed_r && !lg_fire;
    end

    if (db_fire && (pressed_now != pressed_r)) begin
      result.short_press = pressed_r && (held_inc <= cfg.short_max_ticks);
      pressed_nxt        = pressed_now;
      held_nxt           = '0;
    end
    result.long_press = lg_fire && pressed_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b1;
      db_left_r    <= '0;
      db_armed_r   <= 1'b0;
      lg_left_r    <= '0;
      lg_armed_r   <= 1'b0;
      pressed_r    <= 1'b0;
      held_r       <= '0;
    end else if (step_en) begin
      prev_level_r <= prev_level_nxt;
      db_left_r    <= db_left_nxt;
      db_armed_r   <= db_armed_nxt;
      lg_left_r    <= lg_left_nxt;
      lg_armed_r   <= lg_armed_nxt;
      pressed_r    <= pressed_nxt;
      held_r       <= held_nxt;
    end
  end

  assign status.pin_edge       = pin_edge;
  assign status.pressed        = pressed_r;
  assign status.debounce_armed = db_armed_r;
  assign status.long_armed     = lg_armed_r;

endmodule

/* design/button_press_classifier_core.sv */
// Top level of the button press classifier: input register, step unit, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in_     | in        | in_valid / in_stall | in_pin_level
//  out_    | out       | out_valid/out_stall | out_short_press, out_long_press
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_stall is low; the result beat passes through the input
// register, then the step logic into the result register.
// The classifier state loop (countdowns, debounced level, held time) closes inside the
// step unit, so consecutive ticks go through without bubbles.
// rst_n is synchronous, active low; it empties both stages and loads register defaults.
// out_stall holds the result register; a full input register then raises in_stall.
// cfg_ready is always high; countdown lengths load at the next pin edge, the short
// limit applies from the next tick.
module button_press_classifier_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pin_level,
  // classification results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_short_press,
  output logic                          out_long_press,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::TickW-1:0]     cfg_wdata
);
  import bpc_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  status_t step_stat;

  logic in_valid_r;
  logic in_level_r;
  logic out_valid_r;
  logic out_short_r;
  logic out_long_r;

  logic out_free;   // result register can take a beat this cycle
  logic step_en;    // buffered tick moves through the step logic
  logic in_take;

  assign cfg_ready = 1'b1;

  bpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_level_r <= in_pin_level;
    end
  end

  bpc_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .level   (in_level_r),
    .cfg     (cfg),
    .result  (step_res),
    .status  (step_stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_short_r <= step_res.short_press;
      out_long_r  <= step_res.long_press;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_short_press = out_short_r;
  assign out_long_press  = out_long_r;

`ifndef SYNTHESIS
  // backpressure at the input only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  // a pin edge arms both countdowns
  a_edge_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && step_stat.pin_edge) |=> (step_stat.debounce_armed && step_stat.long_armed))
    else $error("pin edge did not arm countdowns");

  // a short press only comes with a debounced release
  a_short_release: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && step_res.short_press) |=> (!step_stat.pressed && out_valid))
    else $error("short press without a release");
`endif

endmodule
